// ----- sv/vic_pkg.sv -----
// Shared types and constants for the clamped velocity integrator.
// No dependencies; every other file imports this package.
package vic_pkg;

	localparam int DATA_W = 32;              // Q16.16 vector component
	localparam int CFG_W  = 31;              // configuration register width
	localparam int DT_W   = 21;              // time step width
	localparam int ACC_W  = 42;              // saturated acceleration magnitude
	localparam int ACC_H  = ACC_W / 2;       // half of it, one partial product
	localparam int PROD_W = DATA_W + CFG_W;  // component times register
	localparam int SUM_W  = 2 * DATA_W;      // sum of squares

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	typedef enum logic [1:0] {
		REG_BODY_MASS   = 2'd0,
		REG_FORCE_LIMIT = 2'd1,
		REG_DRAG_FACTOR = 2'd2,
		REG_SPEED_LIMIT = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] BODY_MASS_RST   = 31'd65536;
	localparam logic [CFG_W-1:0] FORCE_LIMIT_RST = 31'd65536000;
	localparam logic [CFG_W-1:0] DRAG_FACTOR_RST = 31'd0;
	localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 31'd39321600;

	typedef logic [2:0][DATA_W-1:0] vec_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic signed [DATA_W-1:0] force_z;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
		logic [DT_W-1:0]          step_time;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] new_vel_x;
		logic signed [DATA_W-1:0] new_vel_y;
		logic signed [DATA_W-1:0] new_vel_z;
		logic                     was_integrated;
	} out_item_t;

	// magnitude of a two's complement component; the most negative value maps to 2^31
	function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
	endfunction

endpackage

// ----- sv/velocity_integrate_clamped_top.sv -----
// Clamped explicit Euler velocity update, top level. Depends on vic_pkg and vic_clamp.
// Holds the configuration registers and the integration pipeline.
//
// Takes one item per clock whenever start is high (busy stays low) and returns its
// result, marked by done, in order (Q16.16 at the default FRAC_BITS). The item passes
// the force clamp, the force-over-mass divider and the speed clamp: the two vector
// clamps have 68 stages each (a 32-stage square root and a 31-stage divider), the
// divider 32 + FRAC_BITS stages (one quotient bit each), plus nine arithmetic stages.
// The receiver cannot stall: done is high for one cycle and the result must be
// taken then. Write registers only while no item is in flight.
module velocity_integrate_clamped_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  vic_pkg::reg_idx_t         wr_index,
	input  logic [vic_pkg::CFG_W-1:0] wr_data,
	input  logic                      start,
	output logic                      busy,
	input  vic_pkg::in_item_t         item,
	output logic                      done,
	output vic_pkg::out_item_t        result
);
	import vic_pkg::*;

	localparam int QW     = DATA_W + FRAC_BITS;           // force over mass quotient
	localparam int DW     = PROD_W - FRAC_BITS;           // drag term magnitude
	localparam int AW     = ((QW > DW) ? QW : DW) + 2;    // signed acceleration
	localparam int HW     = ACC_H + DT_W;                 // partial product
	localparam int MW     = ACC_W + DT_W;                 // full product
	localparam int PW     = MW - FRAC_BITS;               // velocity increment
	localparam int NW     = ((PW > DATA_W) ? PW : DATA_W) + 2;
	localparam int SIDE_A = 1 + 3 * DATA_W + DT_W;
	localparam int SIDE_B = 1 + 3 * DATA_W;

	localparam logic [DT_W-1:0]  EPS_DT   = DT_W'((1 << FRAC_BITS) / 10000);
	localparam logic [CFG_W-1:0] EPS_MASS = CFG_W'((1 << FRAC_BITS) / 10000);
	localparam logic [SUM_W-1:0] SLEEP_SQ = SUM_W'(10) << (2 * FRAC_BITS);
	localparam logic signed [NW-1:0] N_MAX = (NW'(1) << (DATA_W - 1)) - NW'(1);
	localparam logic signed [NW-1:0] N_MIN = -(NW'(1) << (DATA_W - 1));

	logic [CFG_W-1:0] body_mass_q, force_limit_q, drag_factor_q, speed_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mass_q   <= BODY_MASS_RST;
			force_limit_q <= FORCE_LIMIT_RST;
			drag_factor_q <= DRAG_FACTOR_RST;
			speed_limit_q <= SPEED_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BODY_MASS:   body_mass_q   <= wr_data;
				REG_FORCE_LIMIT: force_limit_q <= wr_data;
				REG_DRAG_FACTOR: drag_factor_q <= wr_data;
				REG_SPEED_LIMIT: speed_limit_q <= wr_data;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---- stage 1: take the item, run the epsilon test
	logic             valid_s1;
	vec_t             f_s1, v_s1;
	logic [DT_W-1:0]  dt_s1;
	logic             run_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		f_s1[0] <= item.force_x;
		f_s1[1] <= item.force_y;
		f_s1[2] <= item.force_z;
		v_s1[0] <= item.vel_x;
		v_s1[1] <= item.vel_y;
		v_s1[2] <= item.vel_z;
		dt_s1   <= item.step_time;
		run_s1  <= (item.step_time > EPS_DT) && (body_mass_q > EPS_MASS);
	end

	// ---- force clamp
	logic              valid_a;
	vec_t              f_a, v_a;
	logic [SIDE_A-1:0] side_a;
	logic [DT_W-1:0]   dt_a;
	logic              run_a;

	vic_clamp #(.SIDE_W(SIDE_A)) u_force_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.vec_in   (f_s1),
		.lim      (force_limit_q),
		.side_in  ({run_s1, v_s1, dt_s1}),
		.out_valid(valid_a),
		.vec_out  (f_a),
		.side_out (side_a)
	);

	assign {run_a, v_a, dt_a} = side_a;

	// ---- stage 2 seeds the mass divider; drag product rides alongside
	logic                  md_v_s     [0:QW];
	logic [2:0][QW-1:0]    md_num_s   [0:QW];
	logic [2:0][CFG_W-1:0] md_rem_s   [0:QW];
	logic [2:0][QW-1:0]    md_quo_s   [0:QW];
	logic [2:0][DW-1:0]    md_dmag_s  [0:QW];
	logic [2:0]            md_fneg_s  [0:QW];
	logic [2:0]            md_vneg_s  [0:QW];
	vec_t                  md_vel_s   [0:QW];
	logic [DT_W-1:0]       md_dt_s    [0:QW];
	logic                  md_run_s   [0:QW];
	logic [2:0][PROD_W-1:0] dprod;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dprod[i] = PROD_W'(mag_of(v_a[i])) * PROD_W'(drag_factor_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_v_s[0] <= 1'b0;
		end else begin
			md_v_s[0] <= valid_a;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			md_num_s[0][i]  <= {mag_of(f_a[i]), {FRAC_BITS{1'b0}}};
			md_dmag_s[0][i] <= dprod[i][PROD_W-1:FRAC_BITS];
			md_fneg_s[0][i] <= f_a[i][DATA_W-1];
			md_vneg_s[0][i] <= v_a[i][DATA_W-1];
		end
		md_rem_s[0] <= '0;
		md_quo_s[0] <= '0;
		md_vel_s[0] <= v_a;
		md_dt_s[0]  <= dt_a;
		md_run_s[0] <= run_a;
	end

	// restoring division by mass, one quotient bit per stage
	for (genvar j = 1; j <= QW; j++) begin : g_mdiv
		logic [2:0][CFG_W:0] t;
		logic [2:0][CFG_W:0] diff;
		logic [2:0]          ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]    = {md_rem_s[j-1][i], md_num_s[j-1][i][QW-1]};
				diff[i] = t[i] - {1'b0, body_mass_q};
				ge[i]   = t[i] >= {1'b0, body_mass_q};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				md_v_s[j] <= 1'b0;
			end else begin
				md_v_s[j] <= md_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				md_rem_s[j][i] <= ge[i] ? diff[i][CFG_W-1:0] : t[i][CFG_W-1:0];
				md_num_s[j][i] <= md_num_s[j-1][i] << 1;
				md_quo_s[j][i] <= {md_quo_s[j-1][i][QW-2:0], ge[i]};
			end
			md_dmag_s[j] <= md_dmag_s[j-1];
			md_fneg_s[j] <= md_fneg_s[j-1];
			md_vneg_s[j] <= md_vneg_s[j-1];
			md_vel_s[j]  <= md_vel_s[j-1];
			md_dt_s[j]   <= md_dt_s[j-1];
			md_run_s[j]  <= md_run_s[j-1];
		end
	end

	// ---- stage 3: acceleration, saturated
	logic                  valid_s3, valid_s4, valid_s5, valid_s6;
	logic [2:0][ACC_W-1:0] amag_s3;
	logic [2:0]            aneg_s3, aneg_s4, aneg_s5;
	vec_t                  v_s3, v_s4, v_s5;
	logic [DT_W-1:0]       dt_s3;
	logic                  run_s3, run_s4, run_s5, run_s6;
	logic signed [AW-1:0]  qs [3];
	logic signed [AW-1:0]  ds [3];
	logic signed [AW-1:0]  acc [3];
	logic [AW-1:0]         amag_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs[i]     = md_fneg_s[QW][i] ? -AW'(md_quo_s[QW][i]) : AW'(md_quo_s[QW][i]);
			ds[i]     = md_vneg_s[QW][i] ? -AW'(md_dmag_s[QW][i]) : AW'(md_dmag_s[QW][i]);
			acc[i]    = qs[i] - ds[i];
			amag_w[i] = acc[i][AW-1] ? -acc[i] : acc[i];
		end
	end

	// ---- stage 4: two partial products; stage 5: sum them; stage 6: add to velocity
	logic [2:0][HW-1:0]     lo_s4, hi_s4;
	logic [2:0][PW-1:0]     pmag_s5;
	logic [2:0][MW-1:0]     full;
	vec_t                   w_s6, v_s6;
	logic signed [NW-1:0]   vs [3];
	logic signed [NW-1:0]   ps [3];
	logic signed [NW-1:0]   nsum [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			full[i] = (MW'(hi_s4[i]) << ACC_H) + MW'(lo_s4[i]);
			vs[i]   = NW'($signed(v_s5[i]));
			ps[i]   = aneg_s5[i] ? -NW'(pmag_s5[i]) : NW'(pmag_s5[i]);
			nsum[i] = vs[i] + ps[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s3 <= md_v_s[QW];
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			aneg_s3[i] <= acc[i][AW-1];
			amag_s3[i] <= (amag_w[i] > AW'(ACC_MAX)) ? ACC_MAX : amag_w[i][ACC_W-1:0];
			lo_s4[i]   <= HW'(amag_s3[i][ACC_H-1:0]) * HW'(dt_s3);
			hi_s4[i]   <= HW'(amag_s3[i][ACC_W-1:ACC_H]) * HW'(dt_s3);
			pmag_s5[i] <= full[i][MW-1:FRAC_BITS];
			priority if (nsum[i] > N_MAX) begin
				w_s6[i] <= N_MAX[DATA_W-1:0];
			end else if (nsum[i] < N_MIN) begin
				w_s6[i] <= N_MIN[DATA_W-1:0];
			end else begin
				w_s6[i] <= nsum[i][DATA_W-1:0];
			end
		end
		v_s3    <= md_vel_s[QW];
		dt_s3   <= md_dt_s[QW];
		run_s3  <= md_run_s[QW];
		aneg_s4 <= aneg_s3;
		v_s4    <= v_s3;
		run_s4  <= run_s3;
		aneg_s5 <= aneg_s4;
		v_s5    <= v_s4;
		run_s5  <= run_s4;
		v_s6    <= v_s5;
		run_s6  <= run_s5;
	end

	// ---- speed clamp
	logic              valid_b;
	vec_t              w_b, v_b;
	logic [SIDE_B-1:0] side_b;
	logic              run_b;

	vic_clamp #(.SIDE_W(SIDE_B)) u_speed_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s6),
		.vec_in   (w_s6),
		.lim      (speed_limit_q),
		.side_in  ({run_s6, v_s6}),
		.out_valid(valid_b),
		.vec_out  (w_b),
		.side_out (side_b)
	);

	assign {run_b, v_b} = side_b;

	// ---- stages 7 and 8: squared speed for the sleep test
	logic                  valid_s7, valid_s8;
	logic [2:0][SUM_W-1:0] sq_s7;
	logic [SUM_W-1:0]      sum_s8;
	vec_t                  w_s7, v_s7, w_s8, v_s8;
	logic                  run_s7, run_s8;
	logic                  sleep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s7 <= valid_b;
			valid_s8 <= valid_s7;
			done     <= valid_s8;
		end
	end

	assign sleep = sum_s8 < SLEEP_SQ;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s7[i] <= SUM_W'(mag_of(w_b[i])) * SUM_W'(mag_of(w_b[i]));
		end
		w_s7   <= w_b;
		v_s7   <= v_b;
		run_s7 <= run_b;
		sum_s8 <= sq_s7[0] + sq_s7[1] + sq_s7[2];
		w_s8   <= w_s7;
		v_s8   <= v_s7;
		run_s8 <= run_s7;
		// drop to rest below the sleep threshold; pass the old velocity when skipped
		result.was_integrated <= run_s8;
		if (!run_s8) begin
			result.new_vel_x <= v_s8[0];
			result.new_vel_y <= v_s8[1];
			result.new_vel_z <= v_s8[2];
		end else if (sleep) begin
			result.new_vel_x <= '0;
			result.new_vel_y <= '0;
			result.new_vel_z <= '0;
		end else begin
			result.new_vel_x <= w_s8[0];
			result.new_vel_y <= w_s8[1];
			result.new_vel_z <= w_s8[2];
		end
	end

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s8 && !run_s8 |=> done && !result.was_integrated &&
			(result.new_vel_x == $past(v_s8[0])) &&
			(result.new_vel_y == $past(v_s8[1])) &&
			(result.new_vel_z == $past(v_s8[2])))
		else $error("skipped item did not pass its velocity through");

	a_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s8 && run_s8 && sleep |=> done && result.was_integrated &&
			(result.new_vel_x == '0) && (result.new_vel_y == '0) &&
			(result.new_vel_z == '0))
		else $error("slow item was not brought to rest");

	a_speed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 |->
			(sq_s7[0] <= SUM_W'(speed_limit_q) * SUM_W'(speed_limit_q)) &&
			(sq_s7[1] <= SUM_W'(speed_limit_q) * SUM_W'(speed_limit_q)) &&
			(sq_s7[2] <= SUM_W'(speed_limit_q) * SUM_W'(speed_limit_q)))
		else $error("component above speed limit after clamp");

endmodule

// ----- sv/vic_clamp.sv -----
// Pipelined vector length clamp: scales a 3-vector down to a length limit.
// Pipelined integer square root and divider, one item per cycle. Uses vic_pkg.
module vic_clamp #(
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  vic_pkg::vec_t            vec_in,
	input  logic [vic_pkg::CFG_W-1:0] lim,
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	output vic_pkg::vec_t            vec_out,
	output logic [SIDE_W-1:0]        side_out
);
	import vic_pkg::*;

	localparam int SQ = DATA_W;   // root bits of a SUM_W radicand
	localparam int DV = CFG_W;    // quotient never exceeds the limit

	typedef struct packed {
		logic [2:0][DATA_W-1:0] mag;
		logic [2:0]             neg;
		logic [2:0][PROD_W-1:0] prod;
		logic                   big;
		logic [SIDE_W-1:0]      side;
	} carry_t;

	// front stages
	logic                   valid_s1, valid_s2, valid_s3;
	logic [2:0][DATA_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]             neg_s1, neg_s2, neg_s3;
	logic [CFG_W-1:0]       lim_s1, lim_s2;
	logic [SIDE_W-1:0]      side_s1, side_s2, side_s3;
	logic [2:0][SUM_W-1:0]  sq_s2;
	logic [SUM_W-1:0]       limsq_s2, limsq_s3, sum_s3;
	logic [2:0][PROD_W-1:0] prod_s3;

	// root and divider stages share one carry line
	logic                   vld_s  [0:SQ+DV];
	carry_t                 cry_s  [0:SQ+DV];
	logic [SUM_W-1:0]       root_s [0:SQ];
	logic [SUM_W-1:0]       rad_s  [0:SQ];
	logic [2:0][PROD_W-1:0] drem_s [1:DV];
	logic [2:0][CFG_W-1:0]  dquo_s [1:DV];
	logic [DATA_W-1:0]      dlen_s [1:DV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			vld_s[0]  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			vld_s[0]  <= valid_s3;
			out_valid <= vld_s[SQ+DV];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_of(vec_in[i]);
			neg_s1[i] <= vec_in[i][DATA_W-1];
			sq_s2[i]  <= SUM_W'(mag_s1[i]) * SUM_W'(mag_s1[i]);
			prod_s3[i] <= PROD_W'(mag_s2[i]) * PROD_W'(lim_s2);
		end
		lim_s1   <= lim;
		side_s1  <= side_in;
		mag_s2   <= mag_s1;
		neg_s2   <= neg_s1;
		lim_s2   <= lim_s1;
		side_s2  <= side_s1;
		limsq_s2 <= SUM_W'(lim_s1) * SUM_W'(lim_s1);
		sum_s3   <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		limsq_s3 <= limsq_s2;
		mag_s3   <= mag_s2;
		neg_s3   <= neg_s2;
		side_s3  <= side_s2;
		// stage four: decide, seed the root
		cry_s[0].mag  <= mag_s3;
		cry_s[0].neg  <= neg_s3;
		cry_s[0].prod <= prod_s3;
		cry_s[0].big  <= sum_s3 > limsq_s3;
		cry_s[0].side <= side_s3;
		root_s[0]     <= '0;
		rad_s[0]      <= sum_s3;
	end

	// one root bit per stage
	for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 * k);
		logic [SUM_W-1:0] trial;
		logic             fit;

		always_comb begin
			trial = root_s[k-1] + BIT;
			fit   = rad_s[k-1] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			cry_s[k] <= cry_s[k-1];
			if (fit) begin
				rad_s[k]  <= rad_s[k-1] - trial;
				root_s[k] <= (root_s[k-1] >> 1) + BIT;
			end else begin
				rad_s[k]  <= rad_s[k-1];
				root_s[k] <= root_s[k-1] >> 1;
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= DV; j++) begin : g_div
		localparam int B = DV - j;
		logic [2:0][PROD_W-1:0] rem_in;
		logic [2:0][CFG_W-1:0]  quo_in;
		logic [2:0][CFG_W-1:0]  quo_nx;
		logic [DATA_W-1:0]      len_in;
		logic [PROD_W-1:0]      dvs;
		logic [2:0]             ge;

		if (j == 1) begin : g_first
			always_comb begin
				rem_in = cry_s[SQ].prod;
				quo_in = '0;
				len_in = root_s[SQ][DATA_W-1:0];
			end
		end else begin : g_next
			always_comb begin
				rem_in = drem_s[j-1];
				quo_in = dquo_s[j-1];
				len_in = dlen_s[j-1];
			end
		end

		always_comb begin
			dvs = PROD_W'(len_in) << B;
			for (int i = 0; i < 3; i++) begin
				ge[i]        = rem_in[i] >= dvs;
				quo_nx[i]    = quo_in[i];
				quo_nx[i][B] = ge[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[SQ+j] <= 1'b0;
			end else begin
				vld_s[SQ+j] <= vld_s[SQ+j-1];
			end
		end

		always_ff @(posedge clk) begin
			cry_s[SQ+j] <= cry_s[SQ+j-1];
			dlen_s[j]   <= len_in;
			dquo_s[j]   <= quo_nx;
			for (int i = 0; i < 3; i++) begin
				drem_s[j][i] <= ge[i] ? (rem_in[i] - dvs) : rem_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cry_s[SQ+DV].big) begin
				vec_out[i] <= cry_s[SQ+DV].neg[i] ? -DATA_W'(dquo_s[DV][i])
				                                  :  DATA_W'(dquo_s[DV][i]);
			end else begin
				vec_out[i] <= cry_s[SQ+DV].neg[i] ? -cry_s[SQ+DV].mag[i]
				                                  :  cry_s[SQ+DV].mag[i];
			end
		end
		side_out <= cry_s[SQ+DV].side;
	end

	// a vector over the limit is never of zero length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ] && cry_s[SQ].big |-> root_s[SQ] != '0)
		else $error("clamp length is zero on a long vector");

	// scaling only ever shrinks a component
	a_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ+DV] && cry_s[SQ+DV].big |->
			(DATA_W'(dquo_s[DV][0]) <= cry_s[SQ+DV].mag[0]) &&
			(DATA_W'(dquo_s[DV][1]) <= cry_s[SQ+DV].mag[1]) &&
			(DATA_W'(dquo_s[DV][2]) <= cry_s[SQ+DV].mag[2]))
		else $error("clamped component grew");

endmodule
